>>> design/qte_pkg.sv
`default_nettype none

package qte_pkg;

    // Field widths of the data path.
    localparam int QW = 16;          // raw quaternion component
    localparam int AW = 34;          // atan2 operands and sums of products
    localparam int CW = 45;          // CORDIC vector after normalization
    localparam int ZW = 34;          // angle accumulator, radians in Q30
    localparam int NW = 41;          // magnitude tracked during normalization
    localparam int SQ_STEPS = 32;    // one result bit of the square root per stage

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int CORDIC_STAGES_MAX = 24;

    // Pi/2 in Q30, degree factor 23040/pi in Q18, limits pi in Q13, 180 in Q7.
    localparam logic signed [ZW-1:0] HALFPI_Q30 = 34'sd1686629713;
    localparam logic [30:0]          DEG_K_Q18  = 31'd1922527338;
    localparam logic [15:0]          RAD_FULL   = 16'd25736;
    localparam logic [15:0]          DEG_FULL   = 16'd23040;

    // One input beat.
    typedef struct packed {
        logic signed [QW-1:0] quat_w;
        logic signed [QW-1:0] quat_x;
        logic signed [QW-1:0] quat_y;
        logic signed [QW-1:0] quat_z;
    } quat_t;

    // One result beat.
    typedef struct packed {
        logic signed [15:0] yaw_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] roll_angle;
        logic               zero_norm;
    } euler_t;

    // Operands and flags that wait beside the square root.
    typedef struct packed {
        logic signed [AW-1:0] roll_num;
        logic signed [AW-1:0] roll_den;
        logic signed [AW-1:0] yaw_num;
        logic signed [AW-1:0] yaw_den;
        logic signed [AW-1:0] pitch_num;
        logic                 zero;
        logic                 degen;
        logic                 sneg;
    } side_t;

    // Flags that wait beside the CORDIC units.
    typedef struct packed {
        logic zero;
        logic degen;
        logic sneg;
    } flags_t;

    // Arctangent of 2^-i in Q30 radians.
    function automatic logic [29:0] atan_entry(input int i);
        logic [29:0] v;
        case (i)
            0:  v = 30'd843314857;
            1:  v = 30'd497837830;
            2:  v = 30'd263043837;
            3:  v = 30'd133525159;
            4:  v = 30'd67021687;
            5:  v = 30'd33543516;
            6:  v = 30'd16775851;
            7:  v = 30'd8388438;
            8:  v = 30'd4194283;
            9:  v = 30'd2097149;
            10: v = 30'd1048576;
            11: v = 30'd524288;
            12: v = 30'd262144;
            13: v = 30'd131072;
            14: v = 30'd65536;
            15: v = 30'd32768;
            16: v = 30'd16384;
            17: v = 30'd8192;
            18: v = 30'd4096;
            19: v = 30'd2048;
            20: v = 30'd1024;
            21: v = 30'd512;
            22: v = 30'd256;
            23: v = 30'd128;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

>>> design/qte_delay.sv
`default_nettype none

module qte_delay
    import qte_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1
)
(
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [WIDTH-1:0] d,
    output logic      [WIDTH-1:0] q
);

    logic [WIDTH-1:0] tap_reg [0:DEPTH-1];

    // Shift line that advances with the pipeline.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign q = tap_reg[DEPTH-1];

endmodule

`default_nettype wire

>>> design/qte_isqrt.sv
`default_nettype none

module qte_isqrt
    import qte_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        en,
    input  wire logic        vld_in,
    input  wire logic [63:0] val_in,
    output logic             vld_out,
    output logic [31:0]      root_out
);

    logic [63:0] v_reg   [0:SQ_STEPS];
    logic [63:0] r_reg   [0:SQ_STEPS];
    logic        vld_reg [0:SQ_STEPS];

    always_comb
    begin
        v_reg[0]   = val_in;
        r_reg[0]   = 64'd0;
        vld_reg[0] = vld_in;
    end

    // One result bit per stage, from the top pair of bits down.
    for (genvar j = 0; j < SQ_STEPS; j++)
    begin : g_step
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
        logic [63:0] trial;
        logic [63:0] v_next;
        logic [63:0] r_next;

        always_comb
        begin
            trial = r_reg[j] + BIT;
            if (v_reg[j] >= trial)
            begin
                v_next = v_reg[j] - trial;
                r_next = (r_reg[j] >> 1) + BIT;
            end
            else
            begin
                v_next = v_reg[j];
                r_next = r_reg[j] >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[j+1] <= vld_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v_reg[j+1] <= v_next;
                r_reg[j+1] <= r_next;
            end
        end
    end

    assign vld_out  = vld_reg[SQ_STEPS];
    assign root_out = r_reg[SQ_STEPS][31:0];

endmodule

`default_nettype wire

>>> design/qte_cordic.sv
`default_nettype none

module qte_cordic
    import qte_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 vld_in,
    input  wire logic signed [AW-1:0] y_in,
    input  wire logic signed [AW-1:0] x_in,
    output logic                      vld_out,
    output logic signed [ZW-1:0]      z_out
);

    // Normalization: three stages of conditional left shifts.
    logic                 n0_vld_reg, n1_vld_reg, n2_vld_reg, q_vld_reg;
    logic signed [CW-1:0] n0_x_reg, n0_y_reg, n1_x_reg, n1_y_reg, n2_x_reg, n2_y_reg;
    logic [NW-1:0]        n0_m_reg, n1_m_reg;
    logic                 n0_zf_reg, n1_zf_reg, n2_zf_reg, q_zf_reg;

    logic [AW-1:0]        ax, ay, am;
    logic signed [CW-1:0] n0_x_next, n0_y_next, n1_x_next, n1_y_next;
    logic signed [CW-1:0] n2_x_next, n2_y_next;
    logic [NW-1:0]        n0_m_next, n1_m_next, n2_m;

    always_comb
    begin
        ax = x_in[AW-1] ? AW'(-x_in) : AW'(x_in);
        ay = y_in[AW-1] ? AW'(-y_in) : AW'(y_in);
        am = (ax > ay) ? ax : ay;
        n0_x_next = CW'(x_in);
        n0_y_next = CW'(y_in);
        n0_m_next = NW'(am);
        if (n0_m_next[NW-1:9] == '0)
        begin
            n0_x_next = n0_x_next <<< 32;
            n0_y_next = n0_y_next <<< 32;
            n0_m_next = n0_m_next << 32;
        end
    end

    always_comb
    begin
        n1_x_next = n0_x_reg;
        n1_y_next = n0_y_reg;
        n1_m_next = n0_m_reg;
        if (n1_m_next[NW-1:25] == '0)
        begin
            n1_x_next = n1_x_next <<< 16;
            n1_y_next = n1_y_next <<< 16;
            n1_m_next = n1_m_next << 16;
        end
        if (n1_m_next[NW-1:33] == '0)
        begin
            n1_x_next = n1_x_next <<< 8;
            n1_y_next = n1_y_next <<< 8;
            n1_m_next = n1_m_next << 8;
        end
    end

    always_comb
    begin
        n2_x_next = n1_x_reg;
        n2_y_next = n1_y_reg;
        n2_m      = n1_m_reg;
        if (n2_m[NW-1:37] == '0)
        begin
            n2_x_next = n2_x_next <<< 4;
            n2_y_next = n2_y_next <<< 4;
            n2_m      = n2_m << 4;
        end
        if (n2_m[NW-1:39] == '0)
        begin
            n2_x_next = n2_x_next <<< 2;
            n2_y_next = n2_y_next <<< 2;
            n2_m      = n2_m << 2;
        end
        if (!n2_m[NW-1])
        begin
            n2_x_next = n2_x_next <<< 1;
            n2_y_next = n2_y_next <<< 1;
        end
    end

    // Rotation stage arrays; entry 0 is the quadrant-corrected vector.
    logic signed [CW-1:0] x_reg   [0:CORDIC_STAGES];
    logic signed [CW-1:0] y_reg   [0:CORDIC_STAGES];
    logic signed [ZW-1:0] z_reg   [0:CORDIC_STAGES];
    logic                 zf_reg  [0:CORDIC_STAGES];
    logic                 vld_reg [0:CORDIC_STAGES];

    logic signed [CW-1:0] q_x_next, q_y_next;
    logic signed [ZW-1:0] q_z_next;

    // Fold the left half plane onto the right one.
    always_comb
    begin
        q_x_next = n2_x_reg;
        q_y_next = n2_y_reg;
        q_z_next = '0;
        if (n2_x_reg < 0)
        begin
            if (n2_y_reg >= 0)
            begin
                q_x_next = n2_y_reg;
                q_y_next = -n2_x_reg;
                q_z_next = HALFPI_Q30;
            end
            else
            begin
                q_x_next = -n2_y_reg;
                q_y_next = n2_x_reg;
                q_z_next = -HALFPI_Q30;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n0_vld_reg <= 1'b0;
            n1_vld_reg <= 1'b0;
            n2_vld_reg <= 1'b0;
            q_vld_reg  <= 1'b0;
        end
        else if (en)
        begin
            n0_vld_reg <= vld_in;
            n1_vld_reg <= n0_vld_reg;
            n2_vld_reg <= n1_vld_reg;
            q_vld_reg  <= n2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n0_x_reg  <= n0_x_next;
            n0_y_reg  <= n0_y_next;
            n0_m_reg  <= n0_m_next;
            n0_zf_reg <= (am == '0);
            n1_x_reg  <= n1_x_next;
            n1_y_reg  <= n1_y_next;
            n1_m_reg  <= n1_m_next;
            n1_zf_reg <= n0_zf_reg;
            n2_x_reg  <= n2_x_next;
            n2_y_reg  <= n2_y_next;
            n2_zf_reg <= n1_zf_reg;
            q_zf_reg  <= n2_zf_reg;
            x_reg[0]  <= q_x_next;
            y_reg[0]  <= q_y_next;
            z_reg[0]  <= q_z_next;
        end
    end

    always_comb
    begin
        zf_reg[0]  = q_zf_reg;
        vld_reg[0] = q_vld_reg;
    end

    // One micro-rotation per stage, shift amount fixed by the stage.
    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_rot
        localparam logic signed [ZW-1:0] ANG = $signed(ZW'(atan_entry(i)));
        logic signed [CW-1:0] xs, ys;

        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                zf_reg[i+1] <= zf_reg[i];
                if (y_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] + ys;
                    y_reg[i+1] <= y_reg[i] - xs;
                    z_reg[i+1] <= z_reg[i] + ANG;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - ys;
                    y_reg[i+1] <= y_reg[i] + xs;
                    z_reg[i+1] <= z_reg[i] - ANG;
                end
            end
        end
    end

    // Both operands zero give a zero angle.
    assign vld_out = vld_reg[CORDIC_STAGES];
    assign z_out   = zf_reg[CORDIC_STAGES] ? '0 : z_reg[CORDIC_STAGES];

endmodule

`default_nettype wire

>>> design/qte_convert.sv
`default_nettype none

module qte_convert
    import qte_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 vld_in,
    input  wire logic                 degree_mode,
    input  wire logic signed [ZW-1:0] z_in,
    output logic                      vld_out,
    output logic signed [15:0]        angle_out
);

    logic          c1_vld_reg, c2_vld_reg;
    logic          c1_neg_reg, c1_mode_reg;
    logic [32:0]   c1_u_reg;
    logic [63:0]   c1_prod_reg;
    logic [32:0]   u_next;
    logic [63:0]   prod_next;
    logic [64:0]   deg_sum;
    logic [33:0]   rad_sum;
    logic [16:0]   r;
    logic [15:0]   full, clamped;
    logic signed [15:0] angle_next;
    logic signed [15:0] angle_reg;

    // Magnitude and the degree product.
    always_comb
    begin
        u_next    = z_in[ZW-1] ? 33'(-z_in) : 33'(z_in);
        prod_next = u_next * DEG_K_Q18;
    end

    // Round half away from zero, clamp, restore the sign.
    always_comb
    begin
        deg_sum = 65'(c1_prod_reg) + (65'd1 << 47);
        rad_sum = 34'(c1_u_reg) + (34'd1 << 16);
        if (c1_mode_reg)
        begin
            r    = deg_sum[64:48];
            full = DEG_FULL;
        end
        else
        begin
            r    = rad_sum[33:17];
            full = RAD_FULL;
        end
        clamped    = (r > 17'(full)) ? full : r[15:0];
        angle_next = c1_neg_reg ? -$signed(clamped) : $signed(clamped);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_vld_reg <= 1'b0;
            c2_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            c1_vld_reg <= vld_in;
            c2_vld_reg <= c1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_neg_reg  <= z_in[ZW-1];
            c1_mode_reg <= degree_mode;
            c1_u_reg    <= u_next;
            c1_prod_reg <= prod_next;
            angle_reg   <= angle_next;
        end
    end

    assign vld_out   = c2_vld_reg;
    assign angle_out = angle_reg;

endmodule

`default_nettype wire

>>> design/quaternion_to_euler_angles.sv
`default_nettype none

// Channel  Valid        Ready        Payload
// -------  -----------  -----------  ------------------------------
// input    quat_valid   quat_ready   quat    (quat_t)
// output   euler_valid  euler_ready  euler   (euler_t)
// config   cfg_valid    cfg_ready    cfg_data (degree_mode)
//
// One beat enters per cycle while the output is not stalled. The path runs through four stages of
// products and sums, 32 square-root stages, the CORDIC chain (four setup stages plus
// one per iteration) and two conversion stages.
// Reset clears the valid bits and sets degree_mode to 1.
// The whole pipeline holds while a result waits at the output and is not taken.
module quaternion_to_euler_angles
    import qte_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   quat_valid,
    output logic        quat_ready,
    input  wire quat_t  quat,
    output logic        euler_valid,
    input  wire logic   euler_ready,
    output euler_t      euler,
    input  wire logic   cfg_valid,
    output logic        cfg_ready,
    input  wire logic   cfg_data
);

    localparam int SIDE_DEPTH = 2 + SQ_STEPS;
    localparam int FLAG_DEPTH = 4 + CORDIC_STAGES;

    logic adv;
    logic degree_mode_reg;

    assign adv        = !euler_valid || euler_ready;
    assign quat_ready = adv;
    assign cfg_ready  = 1'b1;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_mode_reg <= 1'b1;
        end
        else if (cfg_valid)
        begin
            degree_mode_reg <= cfg_data;
        end
    end

    // Stage 1: all pairwise products.
    logic s1_vld_reg;
    logic signed [31:0] ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [31:0] wx_reg, yz_reg, wz_reg, xy_reg, wy_reg, zx_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ww_reg <= quat.quat_w * quat.quat_w;
            xx_reg <= quat.quat_x * quat.quat_x;
            yy_reg <= quat.quat_y * quat.quat_y;
            zz_reg <= quat.quat_z * quat.quat_z;
            wx_reg <= quat.quat_w * quat.quat_x;
            yz_reg <= quat.quat_y * quat.quat_z;
            wz_reg <= quat.quat_w * quat.quat_z;
            xy_reg <= quat.quat_x * quat.quat_y;
            wy_reg <= quat.quat_w * quat.quat_y;
            zx_reg <= quat.quat_z * quat.quat_x;
        end
    end

    // Stage 2: norm and the atan2 operands.
    logic s2_vld_reg;
    logic [32:0]          n_reg;
    logic signed [AW-1:0] rn_reg, rd_reg, yn_reg, yd_reg, s_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n_reg  <= 33'(AW'(ww_reg) + AW'(xx_reg) + AW'(yy_reg) + AW'(zz_reg));
            rn_reg <= (AW'(wx_reg) + AW'(yz_reg)) <<< 1;
            rd_reg <= AW'(ww_reg) + AW'(zz_reg) - AW'(xx_reg) - AW'(yy_reg);
            yn_reg <= (AW'(wz_reg) + AW'(xy_reg)) <<< 1;
            yd_reg <= AW'(ww_reg) + AW'(xx_reg) - AW'(yy_reg) - AW'(zz_reg);
            s_reg  <= (AW'(wy_reg) - AW'(zx_reg)) <<< 1;
        end
    end

    // Pitch scaling: bring the norm below 2^30 before the product.
    logic [1:0]    k;
    logic [AW-1:0] s_mag;
    side_t         side_in, side_out;
    logic signed [AW:0] n_minus_s, n_plus_s;

    always_comb
    begin
        if (n_reg[32])
        begin
            k = 2'd3;
        end
        else if (n_reg[31])
        begin
            k = 2'd2;
        end
        else if (n_reg[30])
        begin
            k = 2'd1;
        end
        else
        begin
            k = 2'd0;
        end
        s_mag              = s_reg[AW-1] ? AW'(-s_reg) : AW'(s_reg);
        n_minus_s          = $signed({2'b00, n_reg}) - (AW+1)'(s_reg);
        n_plus_s           = $signed({2'b00, n_reg}) + (AW+1)'(s_reg);
        side_in.roll_num   = rn_reg;
        side_in.roll_den   = rd_reg;
        side_in.yaw_num    = yn_reg;
        side_in.yaw_den    = yd_reg;
        side_in.pitch_num  = s_reg >>> k;
        side_in.zero       = (n_reg == '0);
        side_in.degen      = (s_mag >= AW'(n_reg));
        side_in.sneg       = s_reg[AW-1];
    end

    // Stage 3 and 4: scaled factors, then their product.
    logic        s3_vld_reg, s4_vld_reg;
    logic [31:0] a_reg, b_reg;
    logic [63:0] ab_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg  <= 32'(n_minus_s >>> k);
            b_reg  <= 32'(n_plus_s >>> k);
            ab_reg <= a_reg * b_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg <= quat_valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
        end
    end

    qte_delay #(
        .WIDTH ($bits(side_t)),
        .DEPTH (SIDE_DEPTH)
    ) u_side_delay (
        .clk (clk),
        .en  (adv),
        .d   (side_in),
        .q   (side_out)
    );

    logic        sq_vld;
    logic [31:0] sq_root;

    qte_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .vld_in   (s4_vld_reg),
        .val_in   (ab_reg),
        .vld_out  (sq_vld),
        .root_out (sq_root)
    );

    // Three atan2 units in lockstep.
    logic                 cd_vld;
    logic signed [ZW-1:0] roll_z, yaw_z, pitch_z;

    qte_cordic #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_cordic_roll (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .vld_in  (sq_vld),
        .y_in    (side_out.roll_num),
        .x_in    (side_out.roll_den),
        .vld_out (),
        .z_out   (roll_z)
    );

    qte_cordic #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_cordic_yaw (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .vld_in  (sq_vld),
        .y_in    (side_out.yaw_num),
        .x_in    (side_out.yaw_den),
        .vld_out (),
        .z_out   (yaw_z)
    );

    qte_cordic #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_cordic_pitch (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .vld_in  (sq_vld),
        .y_in    (side_out.pitch_num),
        .x_in    ($signed({2'b00, sq_root})),
        .vld_out (cd_vld),
        .z_out   (pitch_z)
    );

    flags_t flags_in, flags_out;
    logic   zero_out;

    always_comb
    begin
        flags_in.zero  = side_out.zero;
        flags_in.degen = side_out.degen;
        flags_in.sneg  = side_out.sneg;
    end

    qte_delay #(
        .WIDTH ($bits(flags_t)),
        .DEPTH (FLAG_DEPTH)
    ) u_flag_delay (
        .clk (clk),
        .en  (adv),
        .d   (flags_in),
        .q   (flags_out)
    );

    qte_delay #(
        .WIDTH (1),
        .DEPTH (2)
    ) u_zero_delay (
        .clk (clk),
        .en  (adv),
        .d   (flags_out.zero),
        .q   (zero_out)
    );

    // Pitch at a quarter turn takes the sign of the numerator.
    logic signed [ZW-1:0] pitch_sel;

    always_comb
    begin
        if (flags_out.degen)
        begin
            pitch_sel = flags_out.sneg ? -HALFPI_Q30 : HALFPI_Q30;
        end
        else
        begin
            pitch_sel = pitch_z;
        end
    end

    logic               cv_vld;
    logic signed [15:0] yaw_a, pitch_a, roll_a;

    qte_convert u_conv_yaw (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (adv),
        .vld_in      (cd_vld),
        .degree_mode (degree_mode_reg),
        .z_in        (yaw_z),
        .vld_out     (),
        .angle_out   (yaw_a)
    );

    qte_convert u_conv_pitch (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (adv),
        .vld_in      (cd_vld),
        .degree_mode (degree_mode_reg),
        .z_in        (pitch_sel),
        .vld_out     (cv_vld),
        .angle_out   (pitch_a)
    );

    qte_convert u_conv_roll (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (adv),
        .vld_in      (cd_vld),
        .degree_mode (degree_mode_reg),
        .z_in        (roll_z),
        .vld_out     (),
        .angle_out   (roll_a)
    );

    // An all-zero quaternion forces the angles to zero.
    always_comb
    begin
        euler.yaw_angle   = zero_out ? '0 : yaw_a;
        euler.pitch_angle = zero_out ? '0 : pitch_a;
        euler.roll_angle  = zero_out ? '0 : roll_a;
        euler.zero_norm   = zero_out;
    end

    assign euler_valid = cv_vld;

endmodule

`default_nettype wire

>>> test/tb_quaternion_to_euler_angles.sv
`timescale 1ns / 100ps

module tb_quaternion_to_euler_angles;
    import qte_pkg::*;

    localparam int     STAGES     = 16;
    localparam int     LATENCY    = 42 + STAGES;
    localparam int     CYCLE_CAP  = 400000;
    localparam longint HALF_PI    = 64'sd1686629713;
    localparam longint DEG_K      = 64'sd1922527338;
    localparam longint ATAN_TAB [0:15] = '{
        843314857, 497837830, 263043837, 133525159,
        67021687, 33543516, 16775851, 8388438,
        4194283, 2097149, 1048576, 524288,
        262144, 131072, 65536, 32768
    };

    // Predicts the Euler angles of each accepted quaternion and checks them in order.
    class euler_scoreboard;
        euler_t pending[$];
        bit     deg_mode = 1'b1;
        int     errors   = 0;

        function longint magn(longint v);
            return v < 0 ? -v : v;
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v)
                b = b >> 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        // Vectoring CORDIC, angle in Q30 radians.
        function longint atan2_q30(longint y, longint x);
            longint z;
            longint t;
            longint m;
            longint xs;
            longint ys;
            z = 0;
            if (x == 0 && y == 0)
                return 0;
            m = magn(x) > magn(y) ? magn(x) : magn(y);
            while (m < (64'sd1 <<< 40))
            begin
                m = m * 2;
                x = x * 2;
                y = y * 2;
            end
            if (x < 0)
            begin
                t = x;
                if (y >= 0)
                begin
                    x = y;
                    y = -t;
                    z = HALF_PI;
                end
                else
                begin
                    x = -y;
                    y = t;
                    z = -HALF_PI;
                end
            end
            for (int i = 0; i < STAGES; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0)
                begin
                    x = x + ys;
                    y = y - xs;
                    z = z + ATAN_TAB[i];
                end
                else
                begin
                    x = x - ys;
                    y = y + xs;
                    z = z - ATAN_TAB[i];
                end
            end
            return z;
        endfunction

        // Rounds a Q30 angle to the output unit and saturates it.
        function logic signed [15:0] to_unit(longint a);
            longint unsigned u;
            longint unsigned r;
            longint          full;
            longint          s;
            u = magn(a);
            if (deg_mode)
            begin
                r = (u * DEG_K + (64'd1 << 47)) >> 48;
                full = 23040;
            end
            else
            begin
                r = (u + (64'd1 << 16)) >> 17;
                full = 25736;
            end
            s = r;
            if (s > full)
                s = full;
            if (a < 0)
                s = -s;
            return s[15:0];
        endfunction

        function void note(quat_t q);
            longint w, x, y, z, n, s, pitch;
            longint unsigned a, b;
            int     k;
            euler_t e;
            w = q.quat_w;
            x = q.quat_x;
            y = q.quat_y;
            z = q.quat_z;
            n = w * w + x * x + y * y + z * z;
            e = '0;
            if (n == 0)
                e.zero_norm = 1'b1;
            else
            begin
                e.roll_angle = to_unit(atan2_q30(2 * (w * x + y * z),
                                                 w * w + z * z - x * x - y * y));
                e.yaw_angle  = to_unit(atan2_q30(2 * (w * z + x * y),
                                                 w * w + x * x - y * y - z * z));
                s = 2 * (w * y - z * x);
                // At or beyond a quarter turn the pitch is clamped.
                if (magn(s) >= n)
                    pitch = s < 0 ? -HALF_PI : HALF_PI;
                else
                begin
                    k = 0;
                    while ((n >>> k) >= (64'sd1 <<< 30))
                        k++;
                    a = longint'(n - s) >> k;
                    b = longint'(n + s) >> k;
                    pitch = atan2_q30(s >>> k, int_sqrt(a * b));
                end
                e.pitch_angle = to_unit(pitch);
            end
            pending.push_back(e);
        endfunction

        function void check(euler_t r);
            euler_t e;
            if (pending.size() == 0)
            begin
                $error("result beat with no expectation: %h", r);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (r.yaw_angle !== e.yaw_angle)
            begin
                $error("yaw_angle expected %0d actual %0d", e.yaw_angle, r.yaw_angle);
                errors++;
            end
            if (r.pitch_angle !== e.pitch_angle)
            begin
                $error("pitch_angle expected %0d actual %0d", e.pitch_angle, r.pitch_angle);
                errors++;
            end
            if (r.roll_angle !== e.roll_angle)
            begin
                $error("roll_angle expected %0d actual %0d", e.roll_angle, r.roll_angle);
                errors++;
            end
            if (r.zero_norm !== e.zero_norm)
            begin
                $error("zero_norm expected %0b actual %0b", e.zero_norm, r.zero_norm);
                errors++;
            end
        endfunction
    endclass

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   quat_valid = 1'b0;
    logic   quat_ready;
    quat_t  quat = '0;
    logic   euler_valid;
    logic   euler_ready = 1'b0;
    euler_t euler;
    logic   cfg_valid = 1'b0;
    logic   cfg_ready;
    logic   cfg_data = 1'b0;

    euler_scoreboard board = new();
    bit     no_idle   = 1'b0;
    bit     hold_req  = 1'b0;
    int     hold_left = 0;
    int     cycles    = 0;

    quaternion_to_euler_angles #(.CORDIC_STAGES(STAGES)) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .quat_valid  (quat_valid),
        .quat_ready  (quat_ready),
        .quat        (quat),
        .euler_valid (euler_valid),
        .euler_ready (euler_ready),
        .euler       (euler),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog on the cycle count.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("tb_quaternion_to_euler_angles NOT OK");
            $finish;
        end
    end

    // Monitor: note accepted quaternions, check accepted results.
    always @(posedge clk)
    begin
        if (rst_n && quat_valid && quat_ready)
            board.note(quat);
        if (rst_n && euler_valid && euler_ready)
            board.check(euler);
    end

    // Receiver: random stalls, and one long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_req && hold_left == 0)
        begin
            hold_req = 1'b0;
            hold_left = 400;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            euler_ready <= 1'b0;
        end
        else
            euler_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 34);
    end

    task automatic send_quat(quat_t q);
        while (!no_idle && $urandom_range(99) < 34)
        begin
            quat_valid <= 1'b0;
            @(posedge clk);
        end
        quat <= q;
        quat_valid <= 1'b1;
        @(posedge clk);
        while (!quat_ready)
            @(posedge clk);
    endtask

    task automatic send_parts(int w, int x, int y, int z);
        quat_t q;
        q.quat_w = 16'(w);
        q.quat_x = 16'(x);
        q.quat_y = 16'(y);
        q.quat_z = 16'(z);
        send_quat(q);
    endtask

    // Writes the mode register once the pipeline has drained.
    task automatic set_mode(bit m);
        quat_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
        cfg_data <= m;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        board.deg_mode = m;
    endtask

    task automatic send_directed();
        send_parts(0, 0, 0, 0);
        send_parts(32767, 32767, 32767, 32767);
        send_parts(-32768, -32768, -32768, -32768);
        send_parts(32767, 0, 0, 0);
        send_parts(-32768, 0, 0, 0);
        send_parts(0, 32767, 0, 0);
        send_parts(0, 0, -32768, 0);
        send_parts(0, 0, 0, 32767);
        // Gimbal lock both ways.
        send_parts(20000, 0, 20000, 0);
        send_parts(20000, 0, -20000, 0);
        send_parts(0, 32767, 0, -32768);
        send_parts(1, 0, 0, 0);
        send_parts(0, 0, 0, -1);
        send_parts(-32768, 32767, -32768, 32767);
        send_parts(12345, -23456, 3456, -456);
        send_parts(16384, 16384, -16384, 16384);
    endtask

    task automatic send_random(int count);
        quat_t q;
        int    kind;
        int    v;
        for (int i = 0; i < count; i++)
        begin
            kind = $urandom_range(9);
            q[31:0] = $urandom_range(32'hFFFF_FFFF);
            q[63:32] = $urandom_range(32'hFFFF_FFFF);
            if (kind == 0)
            begin
                // Small components.
                q.quat_w = 16'($signed($urandom_range(8)) - 4);
                q.quat_x = 16'($signed($urandom_range(8)) - 4);
                q.quat_y = 16'($signed($urandom_range(8)) - 4);
                q.quat_z = 16'($signed($urandom_range(8)) - 4);
            end
            else if (kind == 1)
            begin
                // Near the quarter-turn pitch.
                v = $urandom_range(32767);
                q.quat_w = 16'(v);
                q.quat_y = 16'(($urandom_range(1) ? v : -v) + $signed($urandom_range(4)) - 2);
                q.quat_x = 16'($signed($urandom_range(6)) - 3);
                q.quat_z = 16'($signed($urandom_range(6)) - 3);
            end
            send_quat(q);
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_mode(1'b1);
        send_directed();
        set_mode(1'b0);
        send_directed();

        set_mode(1'b0);
        send_random(200);
        no_idle = 1'b1;
        send_random(200);
        no_idle = 1'b0;
        hold_req = 1'b1;
        send_random(200);

        set_mode(1'b1);
        send_random(300);
        set_mode(1'b0);
        send_random(150);
        set_mode(1'b1);
        send_random(150);
        quat_valid <= 1'b0;

        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
        if (board.errors == 0)
            $display("tb_quaternion_to_euler_angles OK");
        else
            $display("tb_quaternion_to_euler_angles NOT OK");
        $finish;
    end

endmodule
